// File: sv/nearest_centroid_top_k_defines.svh
// assertion macros used by the nearest centroid controller
`ifndef NEAREST_CENTROID_TOP_K_DEFINES_SVH
`define NEAREST_CENTROID_TOP_K_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NCTK_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("nctk assertion failed");

// next-cycle implication
`define NCTK_ASSERT_NXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("nctk assertion failed");

`else

`define NCTK_ASSERT_IMP(label, clk, rst, cond, prop)
`define NCTK_ASSERT_NXT(label, clk, rst, cond, prop)

`endif

`endif

// File: sv/nctk_pkg.sv
`default_nettype none

package nctk_pkg;

   // default sizing of the top level
   localparam int MAX_DIM_DEF      = 128;
   localparam int MAX_CLUSTERS_DEF = 4096;
   localparam int MAX_TOP_DEF      = 16;

   // fixed field widths
   localparam int COMPONENT_BITS     = 16;
   localparam int SUM_BITS           = 40;
   localparam int DIST_BITS          = 39;
   localparam int INDEX_BITS         = 12;
   localparam int SQ_BITS            = 2 * COMPONENT_BITS;
   localparam int DIMENSION_BITS     = 8;
   localparam int CLUSTER_COUNT_BITS = 13;
   localparam int TOP_COUNT_BITS     = 5;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 13;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIMENSION     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLUSTER_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TOP_COUNT     = 2'd2;

   // register reset values
   localparam logic [DIMENSION_BITS-1:0]     DIMENSION_RESET     = 8'd128;
   localparam logic [CLUSTER_COUNT_BITS-1:0] CLUSTER_COUNT_RESET = 13'd4096;
   localparam logic [TOP_COUNT_BITS-1:0]     TOP_COUNT_RESET     = 5'd16;

   // input word ops
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_STREAM = 1'b1;

   typedef struct packed {
      logic                             op;
      logic signed [COMPONENT_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] cluster_index;
      logic [DIST_BITS-1:0]  distance;
      logic                  last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // write query component
      logic stream;      // latch centroid component, read query
      logic square;      // form squared difference
      logic accumulate;  // add into running sum
      logic insert;      // place finished distance in sorted list
      logic emit;        // present one list entry
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_stream;   // op of the word on the request port
      logic vec_end;     // current component closes the centroid
      logic run_end;     // current centroid closes the run
      logic emit_last;   // entry being emitted is the final one
   } status_type;

endpackage

`default_nettype wire

// File: sv/nctk_ram.sv
`default_nettype none

module nctk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: sv/nctk_ctrl.sv
`default_nettype none

`include "nearest_centroid_top_k_defines.svh"

module nctk_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire nctk_pkg::status_type    status,
   output nctk_pkg::cmd_type            cmd
);

   import nctk_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_ACC,
      S_INSERT,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && status.op_stream) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = status.vec_end ? S_INSERT : S_IDLE;
         end
         S_INSERT: begin
            state_in = status.run_end ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            state_in = status.emit_last ? S_IDLE : S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == S_IDLE) && start && !status.op_stream;
      cmd.stream     = (state_ff == S_IDLE) && start && status.op_stream;
      cmd.square     = (state_ff == S_DIFF);
      cmd.accumulate = (state_ff == S_ACC);
      cmd.insert     = (state_ff == S_INSERT);
      cmd.emit       = (state_ff == S_EMIT);
   end

   `NCTK_ASSERT_NXT(a_stream_enters_diff, clock, reset, cmd.stream, state_ff == S_DIFF)
   `NCTK_ASSERT_NXT(a_mid_vector_returns, clock, reset, (state_ff == S_ACC) && !status.vec_end, state_ff == S_IDLE)
   `NCTK_ASSERT_NXT(a_last_emit_frees, clock, reset, (state_ff == S_EMIT) && status.emit_last, !busy)
   `NCTK_ASSERT_IMP(a_no_accept_busy, clock, reset, start && busy, !(cmd.load || cmd.stream))

endmodule

`default_nettype wire

// File: sv/nctk_dp.sv
`default_nettype none

module nctk_dp #(
   parameter int MAX_DIM      = nctk_pkg::MAX_DIM_DEF,
   parameter int MAX_CLUSTERS = nctk_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_TOP      = nctk_pkg::MAX_TOP_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [nctk_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [nctk_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  wire nctk_pkg::req_type                      req_data,
   input  wire nctk_pkg::cmd_type                      cmd,
   output nctk_pkg::status_type                        status,
   output logic                                        rsp_strobe,
   output nctk_pkg::rsp_type                           rsp_data
);

   import nctk_pkg::*;

   localparam int DAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DLW = $clog2(MAX_DIM + 1);
   localparam int CW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int CLW = $clog2(MAX_CLUSTERS + 1);
   localparam int TW  = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int TLW = $clog2(MAX_TOP + 1);

   // configuration
   logic [DIMENSION_BITS-1:0]     dimension_ff;
   logic [CLUSTER_COUNT_BITS-1:0] cluster_count_ff;
   logic [TOP_COUNT_BITS-1:0]     top_count_ff;

   // effective lengths, clamped into range
   logic [DLW-1:0] dim_eff;
   logic [CLW-1:0] nc_eff;
   logic [TLW-1:0] k_eff;

   always_comb begin
      if (dimension_ff == '0) begin
         dim_eff = DLW'(1);
      end else if (32'(dimension_ff) > 32'(MAX_DIM)) begin
         dim_eff = DLW'(MAX_DIM);
      end else begin
         dim_eff = DLW'(dimension_ff);
      end
      if (cluster_count_ff == '0) begin
         nc_eff = CLW'(1);
      end else if (32'(cluster_count_ff) > 32'(MAX_CLUSTERS)) begin
         nc_eff = CLW'(MAX_CLUSTERS);
      end else begin
         nc_eff = CLW'(cluster_count_ff);
      end
      if (top_count_ff == '0) begin
         k_eff = TLW'(1);
      end else if (32'(top_count_ff) > 32'(MAX_TOP)) begin
         k_eff = TLW'(MAX_TOP);
      end else begin
         k_eff = TLW'(top_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff     <= DIMENSION_RESET;
         cluster_count_ff <= CLUSTER_COUNT_RESET;
         top_count_ff     <= TOP_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DIMENSION:     dimension_ff     <= csr_data[DIMENSION_BITS-1:0];
            REG_CLUSTER_COUNT: cluster_count_ff <= csr_data[CLUSTER_COUNT_BITS-1:0];
            REG_TOP_COUNT:     top_count_ff     <= csr_data[TOP_COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // counters
   logic [DAW-1:0]      qptr_ff;
   logic [DAW-1:0]      comp_cnt_ff;
   logic [CW-1:0]       cent_cnt_ff;
   logic [TLW-1:0]      filled_ff;
   logic [TW-1:0]       emit_idx_ff;
   logic                qptr_wrap;

   assign qptr_wrap = (32'(qptr_ff) + 32'd1) >= 32'(dim_eff);

   // query store
   logic [COMPONENT_BITS-1:0] q_rd;

   nctk_ram #(
      .WIDTH(COMPONENT_BITS),
      .DEPTH(MAX_DIM)
   ) u_query (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (qptr_ff),
      .wr_data (req_data.value),
      .rd_addr (comp_cnt_ff),
      .rd_data (q_rd)
   );

   // distance arithmetic
   logic signed [COMPONENT_BITS-1:0]   value_ff;
   logic signed [COMPONENT_BITS:0]     diff;
   logic signed [2*COMPONENT_BITS+1:0] prod;
   logic [SQ_BITS-1:0]                 sq_ff;
   logic [SUM_BITS-1:0]                sum_ff;
   logic [SUM_BITS-1:0]                sum_in;
   logic [SUM_BITS-1:0]                dist_ff;

   assign diff   = $signed({q_rd[COMPONENT_BITS-1], q_rd})
                 - $signed({value_ff[COMPONENT_BITS-1], value_ff});
   assign prod   = diff * diff;
   assign sum_in = sum_ff + SUM_BITS'(sq_ff);

   // sorted list cells
   logic [SUM_BITS-1:0]   best_dist_ff [MAX_TOP];
   logic [INDEX_BITS-1:0] best_idx_ff  [MAX_TOP];
   logic [SUM_BITS-1:0]   shift_dist   [MAX_TOP];
   logic [INDEX_BITS-1:0] shift_idx    [MAX_TOP];
   logic [MAX_TOP-1:0]    le;
   logic [MAX_TOP-1:0]    le_prev;
   logic [MAX_TOP-1:0]    place;
   logic [MAX_TOP-1:0]    upd;
   logic                  insert_ok;
   logic [TLW-1:0]        emit_cnt;

   always_comb begin
      for (int i = 0; i < MAX_TOP; i++) begin
         le[i] = (32'(i) < 32'(filled_ff)) && (32'(i) < 32'(k_eff))
               && (best_dist_ff[i] <= dist_ff);
      end
      le_prev[0]    = 1'b1;
      shift_dist[0] = dist_ff;
      shift_idx[0]  = INDEX_BITS'(cent_cnt_ff);
      for (int i = 1; i < MAX_TOP; i++) begin
         le_prev[i]    = le[i-1];
         shift_dist[i] = best_dist_ff[i-1];
         shift_idx[i]  = best_idx_ff[i-1];
      end
      for (int i = 0; i < MAX_TOP; i++) begin
         place[i] = !le[i] && le_prev[i] && (32'(i) < 32'(k_eff));
         upd[i]   = !le_prev[i] || place[i];
         upd[i]   = upd[i] && (32'(i) < 32'(k_eff));
      end
      insert_ok = |place;
      emit_cnt  = (filled_ff < k_eff) ? filled_ff : k_eff;
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         for (int i = 0; i < MAX_TOP; i++) begin
            if (upd[i]) begin
               best_dist_ff[i] <= place[i] ? dist_ff : shift_dist[i];
               best_idx_ff[i]  <= place[i] ? INDEX_BITS'(cent_cnt_ff) : shift_idx[i];
            end
         end
      end
   end

   // status
   always_comb begin
      status           = '0;
      status.op_stream = (req_data.op == OP_STREAM);
      status.vec_end   = (32'(comp_cnt_ff) + 32'd1) >= 32'(dim_eff);
      status.run_end   = (32'(cent_cnt_ff) + 32'd1) >= 32'(nc_eff);
      status.emit_last = (32'(emit_idx_ff) + 32'd1) >= 32'(emit_cnt);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.stream) begin
         value_ff <= req_data.value;
      end
      if (cmd.square) begin
         sq_ff <= prod[SQ_BITS-1:0];
      end
      if (cmd.accumulate && status.vec_end) begin
         dist_ff <= sum_in;
      end
      if (cmd.emit) begin
         rsp_data.cluster_index <= best_idx_ff[emit_idx_ff];
         rsp_data.distance      <= best_dist_ff[emit_idx_ff][DIST_BITS-1:0];
         rsp_data.last          <= status.emit_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qptr_ff     <= '0;
         comp_cnt_ff <= '0;
         cent_cnt_ff <= '0;
         sum_ff      <= '0;
         filled_ff   <= '0;
         emit_idx_ff <= '0;
         rsp_strobe  <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit;
         if (cmd.load) begin
            qptr_ff <= qptr_wrap ? '0 : qptr_ff + DAW'(1);
         end
         if (cmd.accumulate) begin
            if (status.vec_end) begin
               sum_ff      <= '0;
               comp_cnt_ff <= '0;
            end else begin
               sum_ff      <= sum_in;
               comp_cnt_ff <= comp_cnt_ff + DAW'(1);
            end
         end
         if (cmd.insert) begin
            emit_idx_ff <= '0;
            cent_cnt_ff <= status.run_end ? '0 : cent_cnt_ff + CW'(1);
            if (insert_ok) begin
               filled_ff <= (filled_ff < k_eff) ? filled_ff + TLW'(1) : k_eff;
            end
         end
         if (cmd.emit) begin
            if (status.emit_last) begin
               emit_idx_ff <= '0;
               filled_ff   <= '0;
               qptr_ff     <= '0;
            end else begin
               emit_idx_ff <= emit_idx_ff + TW'(1);
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/nearest_centroid_top_k.sv
// channel   | ports                                  | handshake
// ----------+----------------------------------------+-------------------------------
// request   | start, busy, req_data                  | word taken when start & !busy
// response  | rsp_strobe, rsp_data                   | one word per cycle, no stall
// csr       | csr_valid, csr_ready, csr_index, csr_data | write when valid & ready
//
// op 0 (query load) writes one query component, busy stays low
// op 1 (centroid component) goes through query read, square and accumulate;
//   the closing component of a centroid is followed by the sorted insert
// after the last centroid min(top_count, cluster_count) words follow, one per cycle,
//   each registered in the cycle after its list entry is selected
// reset is synchronous, active high; no clearing pass, the block is ready at once
// csr_ready is always high

`default_nettype none

module nearest_centroid_top_k #(
   parameter int MAX_DIM      = nctk_pkg::MAX_DIM_DEF,
   parameter int MAX_CLUSTERS = nctk_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_TOP      = nctk_pkg::MAX_TOP_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request words
   input  wire logic                                start,
   output logic                                     busy,
   input  wire nctk_pkg::req_type                   req_data,
   // result words
   output logic                                     rsp_strobe,
   output nctk_pkg::rsp_type                        rsp_data,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [nctk_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [nctk_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import nctk_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers may be written at any cycle, the host keeps writes to idle periods
   assign csr_ready = 1'b1;

   // sequencer: load, read, square, accumulate, insert, emit
   nctk_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // query store, squared distance accumulator, sorted list cells
   nctk_dp #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_TOP      (MAX_TOP)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
